>>> src/spf_pkg.sv
package spf_pkg;

    localparam int RULES      = 64;
    localparam int TIMER_BITS = 8;
    localparam int RIDX_W     = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int RCNT_W     = $clog2(RULES + 1);
    localparam int HASH_W     = 16;
    localparam int TABLE_SIZE = 1 << HASH_W;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_RULE   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] BY_CONN    = 2'd0;
    localparam logic [1:0] BY_RULE    = 2'd1;
    localparam logic [1:0] BY_DEFAULT = 2'd2;
    localparam logic [1:0] BY_NONE    = 2'd3;

    localparam logic [1:0] CFG_RULE_COUNT     = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_ACCEPT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT        = 2'd2;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [3:0]  CRC_LAST = 4'd12;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_TICK, ST_TICK_WB, ST_HASH, ST_LOOK_RD,
        ST_LOOK_CHK, ST_RULE_RD, ST_RULE_CMP, ST_ADD, ST_FIN
    } spf_state_t;

    typedef enum logic [2:0] {
        RES_HOLD, RES_CONN_HIT, RES_CONN_MISS, RES_RULE, RES_DEFAULT, RES_NOT_PKT
    } spf_res_t;

    typedef struct packed {
        logic     capture;
        logic     crc_start;
        logic     crc_rev;
        logic     crc_step;
        logic     tmr_rd;
        logic     tmr_refresh;
        logic     tmr_add;
        logic     sweep_rst;
        logic     sweep_clr;
        logic     sweep_tick;
        logic     rule_wr;
        logic     rule_start;
        logic     rule_rd;
        logic     rule_next;
        spf_res_t res_sel;
        logic     out_load;
    } spf_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       syn_tcp;
        logic       known;
        logic       is_tcp;
        logic       crc_done;
        logic       rev;
        logic       timer_live;
        logic       sweep_last;
        logic       rule_end;
        logic       rule_match;
        logic       rule_accept;
        logic       default_accept;
        logic       out_free;
    } spf_stat_t;

endpackage

>>> src/spf_datapath.sv
module spf_datapath
    import spf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  spf_cmd_t    cmd,
    output spf_stat_t   stat,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_sport,
    input  logic [15:0] s_dport,
    input  logic [7:0]  s_protocol,
    input  logic        s_syn_without_ack,
    input  logic [5:0]  s_rule_index,
    input  logic [31:0] s_src_mask,
    input  logic [31:0] s_dst_mask,
    input  logic        s_rule_accept,
    input  logic        s_rule_log,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accept,
    output logic        m_log_request,
    output logic [1:0]  m_decided_by,
    output logic [5:0]  m_matched_rule
);

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] src_mask;
        logic [31:0] dst_ip;
        logic [31:0] dst_mask;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic        accept;
        logic        log;
    } rule_t;

    localparam logic [16:0] TMAX = 17'((1 << TIMER_BITS) - 1);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // configuration
    logic [6:0] rule_count_reg;
    logic       default_accept_reg;
    logic [7:0] timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg     <= 7'd0;
            default_accept_reg <= 1'b1;
            timeout_reg        <= 8'd60;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RULE_COUNT:     rule_count_reg     <= cfg_wdata[6:0];
                CFG_DEFAULT_ACCEPT: default_accept_reg <= cfg_wdata[0];
                CFG_TIMEOUT:        timeout_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [TIMER_BITS-1:0] timeout_val;
    assign timeout_val = ({9'd0, timeout_reg} > TMAX) ? TIMER_BITS'(TMAX)
                                                      : TIMER_BITS'(timeout_reg);

    // captured transaction
    logic [1:0]  command_reg;
    logic [31:0] src_ip_reg, dst_ip_reg, src_mask_reg, dst_mask_reg;
    logic [15:0] sport_reg, dport_reg;
    logic [7:0]  protocol_reg;
    logic        syn_reg, rule_accept_reg, rule_log_reg;
    logic [5:0]  rule_index_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            command_reg     <= s_command;
            src_ip_reg      <= s_src_ip;
            dst_ip_reg      <= s_dst_ip;
            sport_reg       <= s_sport;
            dport_reg       <= s_dport;
            protocol_reg    <= s_protocol;
            syn_reg         <= s_syn_without_ack;
            rule_index_reg  <= s_rule_index;
            src_mask_reg    <= s_src_mask;
            dst_mask_reg    <= s_dst_mask;
            rule_accept_reg <= s_rule_accept;
            rule_log_reg    <= s_rule_log;
        end
    end

    // effective tuple: icmp and unknown take zero ports, unknown is hashed as udp
    logic        is_tcp, is_udp, known;
    logic [15:0] eff_sp, eff_dp;
    logic [7:0]  eff_pr;

    assign is_tcp = protocol_reg == PROTO_TCP;
    assign is_udp = protocol_reg == PROTO_UDP;
    assign known  = is_tcp || is_udp || (protocol_reg == PROTO_ICMP);
    assign eff_sp = (is_tcp || is_udp) ? sport_reg : 16'd0;
    assign eff_dp = (is_tcp || is_udp) ? dport_reg : 16'd0;
    assign eff_pr = known ? protocol_reg : PROTO_UDP;

    // crc over the 13 tuple bytes, one byte a cycle
    logic [15:0] crc_reg, crc_next, hash_reg, fwd_hash_reg;
    logic [3:0]  byte_cnt_reg;
    logic        rev_reg;
    logic [31:0] a_ip, b_ip;
    logic [15:0] a_pt, b_pt;
    logic [7:0]  cur_byte;

    assign a_ip = rev_reg ? dst_ip_reg : src_ip_reg;
    assign b_ip = rev_reg ? src_ip_reg : dst_ip_reg;
    assign a_pt = rev_reg ? eff_dp : eff_sp;
    assign b_pt = rev_reg ? eff_sp : eff_dp;

    always_comb begin
        case (byte_cnt_reg)
            4'd0:    cur_byte = a_ip[7:0];
            4'd1:    cur_byte = a_ip[15:8];
            4'd2:    cur_byte = a_ip[23:16];
            4'd3:    cur_byte = a_ip[31:24];
            4'd4:    cur_byte = b_ip[7:0];
            4'd5:    cur_byte = b_ip[15:8];
            4'd6:    cur_byte = b_ip[23:16];
            4'd7:    cur_byte = b_ip[31:24];
            4'd8:    cur_byte = a_pt[7:0];
            4'd9:    cur_byte = a_pt[15:8];
            4'd10:   cur_byte = b_pt[7:0];
            4'd11:   cur_byte = b_pt[15:8];
            default: cur_byte = eff_pr;
        endcase
    end

    assign crc_next = crc_byte(crc_reg, cur_byte);

    always_ff @(posedge aclk) begin
        if (cmd.crc_start) begin
            crc_reg      <= CRC_INIT;
            byte_cnt_reg <= 4'd0;
            rev_reg      <= cmd.crc_rev;
        end else if (cmd.crc_step) begin
            crc_reg      <= crc_next;
            byte_cnt_reg <= byte_cnt_reg + 4'd1;
            if (byte_cnt_reg == CRC_LAST) begin
                hash_reg <= crc_next;
                if (!rev_reg) begin
                    fwd_hash_reg <= crc_next;
                end
            end
        end
    end

    // connection timers
    logic [TIMER_BITS-1:0] tmr_mem [TABLE_SIZE];
    logic [TIMER_BITS-1:0] tmr_q, tmr_wd;
    logic [HASH_W-1:0]     sweep_addr_reg, wb_addr_reg, tmr_ra, tmr_wa;
    logic                  wb_valid_reg, tmr_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            wb_valid_reg   <= 1'b0;
        end else begin
            wb_valid_reg <= cmd.sweep_tick;
            if (cmd.sweep_rst) begin
                sweep_addr_reg <= '0;
            end else if (cmd.sweep_clr || cmd.sweep_tick) begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wb_addr_reg <= sweep_addr_reg;
    end

    assign tmr_ra = cmd.sweep_tick ? sweep_addr_reg : hash_reg;

    always_comb begin
        tmr_we = 1'b1;
        tmr_wa = sweep_addr_reg;
        tmr_wd = '0;
        if (cmd.sweep_clr) begin
            tmr_wa = sweep_addr_reg;
        end else if (wb_valid_reg) begin
            tmr_wa = wb_addr_reg;
            tmr_wd = (tmr_q != '0) ? tmr_q - 1'b1 : '0;
        end else if (cmd.tmr_refresh) begin
            tmr_wa = hash_reg;
            tmr_wd = timeout_val;
        end else if (cmd.tmr_add) begin
            tmr_wa = fwd_hash_reg;
            tmr_wd = timeout_val;
        end else begin
            tmr_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tmr_rd || cmd.sweep_tick) begin
            tmr_q <= tmr_mem[tmr_ra];
        end
        if (tmr_we) begin
            tmr_mem[tmr_wa] <= tmr_wd;
        end
    end

    // rule table
    rule_t             rule_mem [RULES];
    rule_t             rule_q;
    logic [RCNT_W-1:0] rule_cnt_reg;
    logic              rule_end, rule_match;

    always_ff @(posedge aclk) begin
        if (cmd.rule_wr && (32'(rule_index_reg) < RULES)) begin
            rule_mem[RIDX_W'(rule_index_reg)] <= '{src_ip: src_ip_reg, src_mask: src_mask_reg,
                dst_ip: dst_ip_reg, dst_mask: dst_mask_reg, sport: sport_reg,
                dport: dport_reg, protocol: protocol_reg, accept: rule_accept_reg,
                log: rule_log_reg};
        end
        if (cmd.rule_rd) begin
            rule_q <= rule_mem[rule_cnt_reg[RIDX_W-1:0]];
        end
        if (cmd.rule_start) begin
            rule_cnt_reg <= '0;
        end else if (cmd.rule_next) begin
            rule_cnt_reg <= rule_cnt_reg + 1'b1;
        end
    end

    // rule counts above the table size check the whole table
    assign rule_end = ({25'd0, rule_count_reg} >= 32'(RULES))
                    ? (32'(rule_cnt_reg) >= 32'(RULES))
                    : (32'(rule_cnt_reg) >= {25'd0, rule_count_reg});

    assign rule_match = (((rule_q.src_ip ^ src_ip_reg) & rule_q.src_mask) == 32'd0)
                     && (((rule_q.dst_ip ^ dst_ip_reg) & rule_q.dst_mask) == 32'd0)
                     && (rule_q.protocol == 8'd0 || rule_q.protocol == eff_pr)
                     && (rule_q.sport == 16'd0 || rule_q.sport == eff_sp)
                     && (rule_q.dport == 16'd0 || rule_q.dport == eff_dp);

    // decision and result register
    logic       res_acc_reg, res_lg_reg;
    logic [1:0] res_by_reg;
    logic [5:0] res_idx_reg;

    always_ff @(posedge aclk) begin
        case (cmd.res_sel)
            RES_CONN_HIT: begin
                res_acc_reg <= 1'b1; res_lg_reg <= 1'b0;
                res_by_reg  <= BY_CONN; res_idx_reg <= 6'd0;
            end
            RES_CONN_MISS: begin
                res_acc_reg <= 1'b0; res_lg_reg <= 1'b0;
                res_by_reg  <= BY_CONN; res_idx_reg <= 6'd0;
            end
            RES_RULE: begin
                res_acc_reg <= rule_q.accept;
                res_lg_reg  <= rule_q.log && known;
                res_by_reg  <= BY_RULE;
                res_idx_reg <= 6'(rule_cnt_reg);
            end
            RES_DEFAULT: begin
                res_acc_reg <= default_accept_reg; res_lg_reg <= 1'b0;
                res_by_reg  <= BY_DEFAULT; res_idx_reg <= 6'd0;
            end
            RES_NOT_PKT: begin
                res_acc_reg <= 1'b0; res_lg_reg <= 1'b0;
                res_by_reg  <= BY_NONE; res_idx_reg <= 6'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_accept       <= res_acc_reg;
            m_log_request  <= res_lg_reg;
            m_decided_by   <= res_by_reg;
            m_matched_rule <= res_idx_reg;
        end
    end

    assign stat.command        = command_reg;
    assign stat.syn_tcp        = is_tcp && syn_reg;
    assign stat.known          = known;
    assign stat.is_tcp         = is_tcp;
    assign stat.crc_done       = byte_cnt_reg == CRC_LAST;
    assign stat.rev            = rev_reg;
    assign stat.timer_live     = tmr_q != '0;
    assign stat.sweep_last     = &sweep_addr_reg;
    assign stat.rule_end       = rule_end;
    assign stat.rule_match     = rule_match;
    assign stat.rule_accept    = rule_q.accept;
    assign stat.default_accept = default_accept_reg;
    assign stat.out_free       = !m_valid || m_ready;

endmodule

>>> src/spf_ctrl.sv
module spf_ctrl
    import spf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  spf_stat_t stat,
    output spf_cmd_t  cmd
);

    spf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (stat.sweep_last) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                if (stat.command == CMD_PACKET) state_next = ST_HASH;
                else if (stat.command == CMD_TICK) state_next = ST_TICK;
                else state_next = ST_FIN;
            end
            ST_TICK:     if (stat.sweep_last) state_next = ST_TICK_WB;
            ST_TICK_WB:  state_next = ST_FIN;
            ST_HASH: begin
                if (stat.crc_done) begin
                    state_next = (stat.syn_tcp && !stat.rev) ? ST_RULE_RD : ST_LOOK_RD;
                end
            end
            ST_LOOK_RD:  state_next = ST_LOOK_CHK;
            ST_LOOK_CHK: begin
                if (stat.timer_live) state_next = ST_FIN;
                else if (!stat.rev && stat.known) state_next = ST_HASH;
                else if (stat.is_tcp) state_next = ST_FIN;
                else state_next = ST_RULE_RD;
            end
            ST_RULE_RD: begin
                if (!stat.rule_end) state_next = ST_RULE_CMP;
                else state_next = stat.default_accept ? ST_ADD : ST_FIN;
            end
            ST_RULE_CMP: begin
                if (!stat.rule_match) state_next = ST_RULE_RD;
                else state_next = stat.rule_accept ? ST_ADD : ST_FIN;
            end
            ST_ADD:      state_next = ST_FIN;
            ST_FIN:      if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.res_sel = RES_HOLD;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:    cmd.sweep_clr = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DISPATCH: begin
                cmd.sweep_rst = 1'b1;
                cmd.crc_start = 1'b1;
                cmd.rule_wr   = stat.command == CMD_RULE;
                if (stat.command != CMD_PACKET && stat.command != CMD_TICK) begin
                    cmd.res_sel = RES_NOT_PKT;
                end
            end
            ST_TICK:     cmd.sweep_tick = 1'b1;
            ST_TICK_WB:  cmd.res_sel = RES_NOT_PKT;
            ST_HASH: begin
                cmd.crc_step   = 1'b1;
                cmd.rule_start = 1'b1;
            end
            ST_LOOK_RD:  cmd.tmr_rd = 1'b1;
            ST_LOOK_CHK: begin
                if (stat.timer_live) begin
                    cmd.tmr_refresh = 1'b1;
                    cmd.res_sel     = RES_CONN_HIT;
                end else if (!stat.rev && stat.known) begin
                    // forward miss, try the reversed tuple
                    cmd.crc_start = 1'b1;
                    cmd.crc_rev   = 1'b1;
                end else if (stat.is_tcp) begin
                    cmd.res_sel = RES_CONN_MISS;
                end
            end
            ST_RULE_RD: begin
                if (stat.rule_end) cmd.res_sel = RES_DEFAULT;
                else cmd.rule_rd = 1'b1;
            end
            ST_RULE_CMP: begin
                if (stat.rule_match) cmd.res_sel = RES_RULE;
                else cmd.rule_next = 1'b1;
            end
            ST_ADD:      cmd.tmr_add = 1'b1;
            ST_FIN:      cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/stateful_packet_filter_unit.sv
// stateful packet filter: rule table plus a 64k-entry connection timer table
// input channel s_* carries one command per transaction: packet, timer tick,
// rule write or none (3). every transaction yields exactly one result on m_*.
// config port: cfg_wr_en/cfg_index/cfg_wdata write rule_count (0),
// default_accept (1) and connect_timeout (2); write only while idle.
// a packet hashes its tuple one crc byte a cycle, a timer lookup reads then
// checks the entry, and each rule is read then compared. a syn packet goes
// straight to the rule scan; a connection hit ends after the forward or the
// reversed lookup; a udp/icmp miss tries both and then scans the rules. rule
// writes and command 3 go straight to the result. a timer tick walks the
// timer memory one entry a cycle. throughput is one transaction at a time:
// the next is accepted only once a result is loaded, set by the crc unit and
// the single-read memories. after reset the whole timer memory is cleared;
// s_ready stays low until then (config writes are taken throughout).
// results sit in an output register; a stalled receiver holds m_* stable
// and the next transaction is accepted but waits at the end for the slot.
module stateful_packet_filter_unit
    import spf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_sport,
    input  logic [15:0] s_dport,
    input  logic [7:0]  s_protocol,
    input  logic        s_syn_without_ack,
    input  logic [5:0]  s_rule_index,
    input  logic [31:0] s_src_mask,
    input  logic [31:0] s_dst_mask,
    input  logic        s_rule_accept,
    input  logic        s_rule_log,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accept,
    output logic        m_log_request,
    output logic [1:0]  m_decided_by,
    output logic [5:0]  m_matched_rule
);

    spf_cmd_t  cmd;
    spf_stat_t stat;

    spf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spf_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_command         (s_command),
        .s_src_ip          (s_src_ip),
        .s_dst_ip          (s_dst_ip),
        .s_sport           (s_sport),
        .s_dport           (s_dport),
        .s_protocol        (s_protocol),
        .s_syn_without_ack (s_syn_without_ack),
        .s_rule_index      (s_rule_index),
        .s_src_mask        (s_src_mask),
        .s_dst_mask        (s_dst_mask),
        .s_rule_accept     (s_rule_accept),
        .s_rule_log        (s_rule_log),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accept          (m_accept),
        .m_log_request     (m_log_request),
        .m_decided_by      (m_decided_by),
        .m_matched_rule    (m_matched_rule)
    );

endmodule

>>> src/spf_checker.sv
module spf_checker
    import spf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_accept,
    input logic       m_log_request,
    input logic [1:0] m_decided_by,
    input logic [5:0] m_matched_rule
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accept) && $stable(m_decided_by)
            && $stable(m_matched_rule) && $stable(m_log_request))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_non_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_decided_by == BY_NONE |-> !m_accept && !m_log_request)
        else $error("non-packet result accepts");

    a_rule_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_decided_by != BY_RULE |-> m_matched_rule == 6'd0)
        else $error("rule index without rule decision");

    a_log_rule_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_log_request |-> m_decided_by == BY_RULE)
        else $error("log request not from a rule");

endmodule

bind stateful_packet_filter_unit spf_checker u_spf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_accept       (m_accept),
    .m_log_request  (m_log_request),
    .m_decided_by   (m_decided_by),
    .m_matched_rule (m_matched_rule)
);
